// File: rtl/obb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package obb_pkg;

    localparam int EntryW = 21;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 63;

    localparam logic [CfgIdxW-1:0] RegRotA0 = 3'd0;
    localparam logic [CfgIdxW-1:0] RegRotA1 = 3'd1;
    localparam logic [CfgIdxW-1:0] RegRotA2 = 3'd2;
    localparam logic [CfgIdxW-1:0] RegRotB0 = 3'd3;
    localparam logic [CfgIdxW-1:0] RegRotB1 = 3'd4;
    localparam logic [CfgIdxW-1:0] RegRotB2 = 3'd5;
    localparam logic [CfgIdxW-1:0] RegTransA = 3'd6;
    localparam logic [CfgIdxW-1:0] RegTransB = 3'd7;

    localparam logic [3:0] AxisNone = 4'd15;

    typedef struct packed {
        logic signed [23:0] a_center_x;
        logic signed [23:0] a_center_y;
        logic signed [23:0] a_center_z;
        logic [22:0] a_half_x;
        logic [22:0] a_half_y;
        logic [22:0] a_half_z;
        logic signed [23:0] b_center_x;
        logic signed [23:0] b_center_y;
        logic signed [23:0] b_center_z;
        logic [22:0] b_half_x;
        logic [22:0] b_half_y;
        logic [22:0] b_half_z;
    } obb_in_t;

    typedef struct packed {
        logic overlap;
        logic [3:0] separating_axis;
    } obb_out_t;

    typedef logic signed [EntryW-1:0] ent_t;
    typedef ent_t [2:0][2:0] mat_t;
    typedef ent_t [2:0] vec_t;

    // Per-stage pipeline control travelling between stage modules.
    typedef struct packed {
        logic valid;
        logic advance;
    } stg_ctl_t;

    function automatic logic signed [63:0] floor19(input logic signed [63:0] v);
        return v >>> 19;
    endfunction

    function automatic logic signed [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? -v : v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/obb_separating_axis_test_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Oriented bounding box overlap test over the 15 separating axes.
// Software writes the two object poses (rotation rows and translations)
// through the cfg channel while the block is idle; index i selects the
// register in the order rot_a_row0..2, rot_b_row0..2, trans_a, trans_b.
// Each request on the s_ channel carries two local boxes; each produces
// exactly one result on the m_ channel: an overlap flag and the first axis
// that separates the boxes (15 when they overlap).
// The datapath is a five-stage pipeline: centre products, world offset,
// projection and rotation products, axis terms, then sums and compares.
// m_valid rises when an accepted request reaches the stage-five register;
// one request is accepted in every cycle with s_ready high. The multipliers
// of stages one, three and four set the stage depth. While the receiver
// holds m_ready low, full stages hold in place and empty slots ahead of
// them still fill, so s_ready follows m_ready or an empty slot ahead;
// nothing is lost or repeated. Reset clears the stage valid bits and the
// pose registers to zero; with zero poses every pair reports overlap.
module obb_separating_axis_test_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire obb_pkg::obb_in_t     s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output obb_pkg::obb_out_t         m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [obb_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [obb_pkg::CfgDataW-1:0] cfg_data
);
    import obb_pkg::*;

    logic [CfgDataW-1:0] regs_reg [8];
    logic [4:0] vld_reg;
    logic [4:0] adv;
    mat_t ra, rb;
    vec_t ta, tb;
    stg_ctl_t ctl [5];
    obb_in_t box;
    logic signed [63:0] c [3][3];
    logic signed [63:0] pa [3], pb [3], q [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 8; r++) begin
                regs_reg[r] <= '0;
            end
        end else if (cfg_valid) begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
                ra[r][j] = regs_reg[RegRotA0 + 3'(r)][EntryW*j +: EntryW];
                rb[r][j] = regs_reg[RegRotB0 + 3'(r)][EntryW*j +: EntryW];
            end
            ta[r] = regs_reg[RegTransA][EntryW*r +: EntryW];
            tb[r] = regs_reg[RegTransB][EntryW*r +: EntryW];
        end
    end

    // Stage n advances when its slot is empty or the next stage moves.
    always_comb begin
        adv[4] = !vld_reg[4] || m_ready;
        for (int n = 3; n >= 0; n--) begin
            adv[n] = !vld_reg[n] || adv[n+1];
        end
        for (int n = 0; n < 5; n++) begin
            ctl[n].valid = vld_reg[n];
            ctl[n].advance = adv[n];
        end
    end

    assign s_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) vld_reg[0] <= s_valid;
            for (int n = 1; n < 5; n++) begin
                if (adv[n]) vld_reg[n] <= vld_reg[n-1];
            end
        end
    end

    obb_geom u_geom (
        .aclk    (aclk),
        .ctl1    (ctl[0]),
        .ctl2    (ctl[1]),
        .ctl3    (ctl[2]),
        .ra      (ra),
        .rb      (rb),
        .ta      (ta),
        .tb      (tb),
        .in_item (s_data),
        .box_out (box),
        .c_out   (c),
        .pa_out  (pa),
        .pb_out  (pb),
        .q_out   (q)
    );

    obb_axes u_axes (
        .aclk    (aclk),
        .ctl4    (ctl[3]),
        .ctl5    (ctl[4]),
        .box     (box),
        .c       (c),
        .pa      (pa),
        .pb      (pb),
        .q       (q),
        .res_out (m_data)
    );

    assign m_valid = vld_reg[4];

endmodule
`default_nettype wire

// File: rtl/obb_geom.sv
`timescale 1ns / 1ps
`default_nettype none
// Geometry stages: centre products, world offset D, then C, pA, pB and q.
module obb_geom (
    input  wire logic            aclk,
    input  wire obb_pkg::stg_ctl_t ctl1,
    input  wire obb_pkg::stg_ctl_t ctl2,
    input  wire obb_pkg::stg_ctl_t ctl3,
    input  wire obb_pkg::mat_t   ra,
    input  wire obb_pkg::mat_t   rb,
    input  wire obb_pkg::vec_t   ta,
    input  wire obb_pkg::vec_t   tb,
    input  wire obb_pkg::obb_in_t in_item,
    output obb_pkg::obb_in_t     box_out,
    output logic signed [63:0]   c_out [3][3],
    output logic signed [63:0]   pa_out [3],
    output logic signed [63:0]   pb_out [3],
    output logic signed [63:0]   q_out [3]
);
    import obb_pkg::*;

    logic signed [63:0] sa_reg [3][3], sb_reg [3][3];
    logic signed [63:0] d_reg [3];
    obb_in_t box1_reg, box2_reg, box3_reg;
    logic signed [63:0] pat_reg [3][3], pbt_reg [3][3], ct_reg [3][3][3];
    logic signed [63:0] ca [3], cb [3];

    assign ca[0] = 64'(in_item.a_center_x);
    assign ca[1] = 64'(in_item.a_center_y);
    assign ca[2] = 64'(in_item.a_center_z);
    assign cb[0] = 64'(in_item.b_center_x);
    assign cb[1] = 64'(in_item.b_center_y);
    assign cb[2] = 64'(in_item.b_center_z);

    // Stage 1: product terms of the rotated centres.
    always_ff @(posedge aclk) begin
        if (ctl1.advance) begin
            box1_reg <= in_item;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    sa_reg[k][j] <= 64'(ra[k][j]) * ca[j];
                    sb_reg[k][j] <= 64'(rb[k][j]) * cb[j];
                end
            end
        end
    end

    // Stage 2: world offset D.
    always_ff @(posedge aclk) begin
        if (ctl2.advance) begin
            box2_reg <= box1_reg;
            for (int k = 0; k < 3; k++) begin
                d_reg[k] <= (floor19(sb_reg[k][0] + sb_reg[k][1] + sb_reg[k][2])
                             + 4 * 64'(tb[k]))
                          - (floor19(sa_reg[k][0] + sa_reg[k][1] + sa_reg[k][2])
                             + 4 * 64'(ta[k]));
            end
        end
    end

    // Stage 3: product terms of projections and of C. D always fits in
    // 28 signed bits, so a 32-bit operand carries it exactly.
    always_ff @(posedge aclk) begin
        if (ctl3.advance) begin
            box3_reg <= box2_reg;
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    pat_reg[i][k] <= 64'(ra[k][i]) * 64'(32'(d_reg[k]));
                    pbt_reg[i][k] <= 64'(rb[k][i]) * 64'(32'(d_reg[k]));
                    for (int j = 0; j < 3; j++) begin
                        ct_reg[i][j][k] <= 64'(ra[k][i]) * 64'(rb[k][j]);
                    end
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pa_out[i] = pat_reg[i][0] + pat_reg[i][1] + pat_reg[i][2];
            pb_out[i] = pbt_reg[i][0] + pbt_reg[i][1] + pbt_reg[i][2];
            q_out[i] = floor19(pa_out[i]);
            for (int j = 0; j < 3; j++) begin
                c_out[i][j] = floor19(ct_reg[i][j][0] + ct_reg[i][j][1] + ct_reg[i][j][2]);
            end
        end
    end

    assign box_out = box3_reg;

endmodule
`default_nettype wire

// File: rtl/obb_axes.sv
`timescale 1ns / 1ps
`default_nettype none
// Axis stages: product terms, then sums and compares, then priority pick.
module obb_axes (
    input  wire logic            aclk,
    input  wire obb_pkg::stg_ctl_t ctl4,
    input  wire obb_pkg::stg_ctl_t ctl5,
    input  wire obb_pkg::obb_in_t box,
    input  wire logic signed [63:0] c [3][3],
    input  wire logic signed [63:0] pa [3],
    input  wire logic signed [63:0] pb [3],
    input  wire logic signed [63:0] q [3],
    output obb_pkg::obb_out_t    res_out
);
    import obb_pkg::*;

    logic signed [63:0] ha [3], hb [3], ac [3][3];
    logic signed [63:0] fr_reg [6][4];
    logic signed [63:0] fp_reg [6];
    logic signed [63:0] ep_reg [9][2];
    logic signed [63:0] er_reg [9][4];
    logic [14:0] sep_reg;
    logic [14:0] sep;
    logic [3:0] axis;

    assign ha[0] = 64'(box.a_half_x);
    assign ha[1] = 64'(box.a_half_y);
    assign ha[2] = 64'(box.a_half_z);
    assign hb[0] = 64'(box.b_half_x);
    assign hb[1] = 64'(box.b_half_y);
    assign hb[2] = 64'(box.b_half_z);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ac[i][j] = mag64(c[i][j]);
            end
        end
    end

    // Stage 4: every product term of the radii and edge projections.
    // C stays within 24 signed bits and q within 31, so 32-bit operands
    // hold them exactly.
    always_ff @(posedge aclk) begin
        if (ctl4.advance) begin
            for (int i = 0; i < 3; i++) begin
                fr_reg[i][0] <= ha[i] <<< 19;
                fp_reg[i] <= mag64(pa[i]);
                fr_reg[3+i][0] <= hb[i] <<< 19;
                fp_reg[3+i] <= mag64(pb[i]);
                for (int j = 0; j < 3; j++) begin
                    fr_reg[i][1+j] <= hb[j] * 64'(32'(ac[i][j]));
                    fr_reg[3+i][1+j] <= ha[j] * 64'(32'(ac[j][i]));
                end
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    ep_reg[3*i+j][0] <= 64'(32'(c[(i+1)%3][j])) * 64'(32'(q[(i+2)%3]));
                    ep_reg[3*i+j][1] <= 64'(32'(c[(i+2)%3][j])) * 64'(32'(q[(i+1)%3]));
                    er_reg[3*i+j][0] <= ha[(i+1)%3] * 64'(32'(ac[(i+2)%3][j]));
                    er_reg[3*i+j][1] <= ha[(i+2)%3] * 64'(32'(ac[(i+1)%3][j]));
                    er_reg[3*i+j][2] <= hb[(j+1)%3] * 64'(32'(ac[i][(j+2)%3]));
                    er_reg[3*i+j][3] <= hb[(j+2)%3] * 64'(32'(ac[i][(j+1)%3]));
                end
            end
        end
    end

    // Stage 5: radius sums and strict compares.
    always_comb begin
        for (int n = 0; n < 6; n++) begin
            sep[n] = (fr_reg[n][0] + fr_reg[n][1] + fr_reg[n][2] + fr_reg[n][3]) < fp_reg[n];
        end
        for (int n = 0; n < 9; n++) begin
            sep[6+n] = (er_reg[n][0] + er_reg[n][1] + er_reg[n][2] + er_reg[n][3])
                       < mag64(ep_reg[n][0] - ep_reg[n][1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl5.advance) begin
            sep_reg <= sep;
        end
    end

    // First separating axis in test order.
    always_comb begin
        axis = AxisNone;
        for (int n = 14; n >= 0; n--) begin
            if (sep_reg[n]) begin
                axis = 4'(n);
            end
        end
    end

    assign res_out.overlap = (axis == AxisNone);
    assign res_out.separating_axis = axis;

endmodule
`default_nettype wire
